FILE: rtl/core/fba_pkg.sv
// ----------------------------------------------------------------------------
// Block allocator package
// Shared sizes, request and policy codes, and the scan unit's control types.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  // Index width into the block table and a counter width that can hold the depth.
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths of the channels.
  localparam int REQ_W      = 2;
  localparam int BLK_W      = 4;
  localparam int AMT_W      = 16;
  localparam int POL_W      = 2;
  localparam int BIU_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [31:0] SIZE_MAX_32 = 32'((64'd1 << SIZE_BITS) - 64'd1);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTORE = 2'd2;

  // Fit policy codes; the unused code behaves as first fit.
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  typedef logic [SIZE_BITS-1:0] size_t;

  // One step of the search, from the sequencer to the pick unit.
  typedef struct packed {
    logic             clear;
    logic             step;
    logic [POL_W-1:0] policy;
    logic [IDX_W-1:0] idx;
    size_t            rem;
    logic [AMT_W-1:0] amount;
  } scan_ctl_t;

  // Running choice held by the pick unit.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    size_t            rem;
  } pick_stat_t;

endpackage

FILE: rtl/core/fba_chan_if.sv
// ----------------------------------------------------------------------------
// Block allocator channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface fba_req_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::REQ_W-1:0]   req_type;
  logic [fba_pkg::BLK_W-1:0]   block_index;
  logic [fba_pkg::AMT_W-1:0]   amount;

  modport source (output valid, req_type, block_index, amount, input ready);
  modport sink   (input valid, req_type, block_index, amount, output ready);
endinterface

interface fba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [fba_pkg::BLK_W-1:0]   chosen_block;
  logic [fba_pkg::AMT_W-1:0]   remaining_after;

  modport source (output valid, granted, chosen_block, remaining_after, input ready);
  modport sink   (input valid, granted, chosen_block, remaining_after, output ready);
endinterface

interface fba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fba_pkg::CFG_IDX_W-1:0]   index;
  logic [fba_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/fba_pick_unit.sv
// ----------------------------------------------------------------------------
// Block allocator pick unit
// Shared compare unit that keeps the block chosen by the fit policy during a scan.
// ----------------------------------------------------------------------------
module fba_pick_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  fba_pkg::scan_ctl_t  ctl,
  output fba_pkg::pick_stat_t stat
);

  logic                      found_r;
  logic [fba_pkg::IDX_W-1:0] idx_r;
  fba_pkg::size_t            rem_r;
  logic                      fits;
  logic                      better;

  assign fits = 32'(ctl.rem) >= 32'(ctl.amount);

  // Strict compares keep the lower index on a tie.
  assign better = !found_r
               || ((ctl.policy == fba_pkg::POL_BEST)  && (ctl.rem < rem_r))
               || ((ctl.policy == fba_pkg::POL_WORST) && (ctl.rem > rem_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (ctl.step && fits && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && fits && better) begin
      idx_r <= ctl.idx;
      rem_r <= ctl.rem;
    end
  end

  assign stat.found = found_r;
  assign stat.idx   = idx_r;
  assign stat.rem   = rem_r;

endmodule

FILE: rtl/core/fit_policy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Fit policy block allocator
// Fixed partition allocator with first, best and worst fit over a block table.
// ----------------------------------------------------------------------------
// Sequence: a load or an unused request goes straight to the output handover.
// An allocate searches limit blocks (limit = blocks searched) through the single
// compare unit, one block per cycle, then updates the chosen block; a zero limit
// refuses it at once. A restore walks the whole table. The input reopens once the
// result is handed to the output register, which waits out any output stall.
// Reset (rst_n low at a rising edge) clears both tables, sets first fit and 16.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit (
  input  logic       clk,
  input  logic       rst_n,
  fba_req_if.sink    in_ch,
  fba_rsp_if.source  out_ch,
  fba_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESTORE,
    S_OUT
  } state_t;

  state_t                      state_r;

  // Configuration registers.
  logic [fba_pkg::POL_W-1:0]   policy_r;
  logic [fba_pkg::BIU_W-1:0]   biu_r;

  // The item being worked on.
  logic [fba_pkg::AMT_W-1:0]   op_amt_r;
  logic [fba_pkg::CNT_W-1:0]   cnt_r;
  logic [fba_pkg::CNT_W-1:0]   limit_r;

  // Result waiting for the output register.
  logic                        res_granted_r;
  logic [fba_pkg::BLK_W-1:0]   res_blk_r;
  logic [fba_pkg::AMT_W-1:0]   res_rem_r;

  // Output register.
  logic                        out_valid_r;
  logic                        out_granted_r;
  logic [fba_pkg::BLK_W-1:0]   out_blk_r;
  logic [fba_pkg::AMT_W-1:0]   out_rem_r;

  // Block table: original and remaining sizes.
  fba_pkg::size_t              orig_r [fba_pkg::MAX_BLOCKS];
  fba_pkg::size_t              rem_r  [fba_pkg::MAX_BLOCKS];

  logic                        in_fire;
  logic [fba_pkg::IDX_W-1:0]   scan_idx;
  logic [fba_pkg::IDX_W-1:0]   load_idx;
  logic                        load_ok;
  fba_pkg::size_t              load_size;
  logic [fba_pkg::CNT_W-1:0]   limit;
  fba_pkg::size_t              new_rem;
  fba_pkg::scan_ctl_t          scan_ctl;
  fba_pkg::pick_stat_t         pick;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign scan_idx = cnt_r[fba_pkg::IDX_W-1:0];
  assign load_idx = fba_pkg::IDX_W'(in_ch.block_index);
  assign load_ok  = 32'(in_ch.block_index) < 32'(fba_pkg::MAX_BLOCKS);

  // A load larger than the size range saturates to the largest size.
  assign load_size = (32'(in_ch.amount) > fba_pkg::SIZE_MAX_32)
                   ? fba_pkg::SIZE_BITS'(fba_pkg::SIZE_MAX_32)
                   : fba_pkg::SIZE_BITS'(in_ch.amount);

  // Search count is capped at the table depth.
  assign limit = (32'(biu_r) > 32'(fba_pkg::MAX_BLOCKS))
               ? fba_pkg::CNT_W'(fba_pkg::MAX_BLOCKS)
               : fba_pkg::CNT_W'(biu_r);

  // The chosen block always fits, so this never wraps.
  assign new_rem = pick.rem - fba_pkg::SIZE_BITS'(op_amt_r);

  // One table entry per cycle goes through the shared compare unit.
  assign scan_ctl.clear  = in_fire;
  assign scan_ctl.step   = (state_r == S_SCAN);
  assign scan_ctl.policy = policy_r;
  assign scan_ctl.idx    = scan_idx;
  assign scan_ctl.rem    = rem_r[scan_idx];
  assign scan_ctl.amount = op_amt_r;

  fba_pick_unit u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .stat  (pick)
  );

  // Configuration writes are to arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fba_pkg::POL_FIRST;
      biu_r    <= fba_pkg::BIU_W'(16);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        fba_pkg::CFG_FIT_POLICY:    policy_r <= cfg_ch.data[fba_pkg::POL_W-1:0];
        fba_pkg::CFG_BLOCKS_IN_USE: biu_r    <= cfg_ch.data[fba_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, block table and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      limit_r     <= '0;
      for (int i = 0; i < fba_pkg::MAX_BLOCKS; i++) begin
        orig_r[i] <= '0;
        rem_r[i]  <= '0;
      end
    end else begin
      // In the handover state the output register is reloaded below instead.
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_amt_r <= in_ch.amount;
            cnt_r    <= '0;
            limit_r  <= limit;
            // Only a load inside the table is granted right away.
            if ((in_ch.req_type == fba_pkg::REQ_LOAD) && load_ok) begin
              res_granted_r <= 1'b1;
              res_blk_r     <= in_ch.block_index;
              res_rem_r     <= fba_pkg::AMT_W'(load_size);
            end else begin
              res_granted_r <= 1'b0;
              res_blk_r     <= '0;
              res_rem_r     <= '0;
            end
            case (in_ch.req_type)
              fba_pkg::REQ_LOAD: begin
                // A load outside the table changes nothing and is not granted.
                if (load_ok) begin
                  orig_r[load_idx] <= load_size;
                  rem_r[load_idx]  <= load_size;
                end
                state_r <= S_OUT;
              end
              fba_pkg::REQ_ALLOC: begin
                // With nothing to search the request is simply refused.
                state_r <= (limit == '0) ? S_OUT : S_SCAN;
              end
              fba_pkg::REQ_RESTORE: begin
                state_r <= S_RESTORE;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end

        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r + 1'b1 == limit_r) begin
            state_r <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          if (pick.found) begin
            rem_r[pick.idx] <= new_rem;
            res_granted_r   <= 1'b1;
            res_blk_r       <= fba_pkg::BLK_W'(pick.idx);
            res_rem_r       <= fba_pkg::AMT_W'(new_rem);
          end
          state_r <= S_OUT;
        end

        S_RESTORE: begin
          rem_r[scan_idx] <= orig_r[scan_idx];
          cnt_r           <= cnt_r + 1'b1;
          if (cnt_r == fba_pkg::CNT_W'(fba_pkg::MAX_BLOCKS - 1)) begin
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          // Hand the result over once the output register is free or draining.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_granted_r <= res_granted_r;
            out_blk_r     <= res_blk_r;
            out_rem_r     <= res_rem_r;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.granted         = out_granted_r;
  assign out_ch.chosen_block    = out_blk_r;
  assign out_ch.remaining_after = out_rem_r;

  // An accepted beat closes the input until its result is handed over.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input taken again right after an accepted beat");

  // The scan never walks past the search count.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r < limit_r))
    else $error("scan index beyond search count");

  // A chosen block lies within the searched part of the table.
  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && pick.found) |-> (fba_pkg::CNT_W'(pick.idx) < limit_r))
    else $error("chosen block outside the searched range");

  // A refused beat carries zero block and zero remainder.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_blk_r == '0 && out_rem_r == '0))
    else $error("refused result with nonzero fields");

endmodule
